// ===== rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared constants, queue entry layout and queue status for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   // UTF-16 constants
   localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
   localparam logic [15:0] SURR_MASK        = 16'hF800;
   localparam logic [20:0] SUPP_OFFSET      = 21'h010000;
   localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;

   // Queue between decoder and unit serializer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Units caused by one input byte: one or two
   typedef struct packed {
      logic        two;
      logic [15:0] unit0;
      logic        repl0;
      logic [15:0] unit1;
      logic        repl1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/u8u16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle while the queue has room, tracks the open
// sequence and pushes the UTF-16 units that the byte causes as one entry.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   input  u8u16_pkg::queue_status_type  queue_status,
   output logic                         push,
   output u8u16_pkg::entry_type         push_entry
);

   typedef struct packed {
      logic        emit;
      logic [15:0] unit;
      logic [2:0]  len;
      logic [20:0] cp;
   } lead_type;

   typedef struct packed {
      logic        two;
      logic [15:0] unit0;
      logic        repl0;
      logic [15:0] unit1;
   } finish_type;

   // Classify a byte seen with no sequence open
   function automatic lead_type decode_lead(input logic [7:0] b);
      lead_type l;
      l = '0;
      if (b[7] == 1'b0) begin
         l.emit = 1'b1;
         l.unit = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
         l.len = 3'd2;
         l.cp  = {16'h0000, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         l.len = 3'd3;
         l.cp  = {17'h00000, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         l.len = 3'd4;
         l.cp  = {18'h00000, b[2:0]};
      end else begin
         l.emit = 1'b1;
         l.unit = u8u16_pkg::REPLACEMENT_CHAR;
      end
      return l;
   endfunction

   // Check a completed code point and encode it
   function automatic finish_type finish_cp(input logic [20:0] cp, input logic [2:0] len);
      finish_type  f;
      logic [2:0]  needed;
      logic        bad;
      logic [20:0] cpm;
      f = '0;
      if (cp <= 21'h00007F) begin
         needed = 3'd1;
      end else if (cp <= 21'h0007FF) begin
         needed = 3'd2;
      end else if (cp <= 21'h00FFFF) begin
         needed = 3'd3;
      end else begin
         needed = 3'd4;
      end
      bad = (needed != len)
         || ((cp < 21'h00FFFF) && ((cp[15:0] & u8u16_pkg::SURR_MASK) == u8u16_pkg::HIGH_SURR_BASE))
         || (cp > u8u16_pkg::MAX_CODE_POINT);
      cpm = cp - u8u16_pkg::SUPP_OFFSET;
      if (bad) begin
         f.unit0 = u8u16_pkg::REPLACEMENT_CHAR;
         f.repl0 = 1'b1;
      end else if (cp <= 21'h00FFFF) begin
         f.unit0 = cp[15:0];
      end else begin
         f.two   = 1'b1;
         f.unit0 = u8u16_pkg::HIGH_SURR_BASE | {6'b000000, cpm[19:10]};
         f.unit1 = u8u16_pkg::LOW_SURR_BASE | {6'b000000, cpm[9:0]};
      end
      return f;
   endfunction

   logic [20:0] cp_ff, cp_in;
   logic [2:0]  len_ff, len_in;
   logic [1:0]  seen_ff, seen_in;

   logic        in_fire;
   logic        cont_byte;
   lead_type    lead;
   logic [20:0] cat_cp;
   logic [1:0]  seen_inc;
   logic        complete;
   finish_type  fin;
   logic [1:0]  n;
   logic [15:0] unit_v [2];
   logic        repl_v [2];

   assign req_tready = !queue_status.full;
   assign in_fire    = req_tvalid && req_tready;

   // Per-byte decode terms
   assign cont_byte = (req_tdata[7:6] == 2'b10);
   assign lead      = decode_lead(req_tdata);
   assign cat_cp    = {cp_ff[14:0], req_tdata[5:0]};
   assign seen_inc  = seen_ff + 2'd1;
   assign complete  = (({1'b0, seen_inc} + 3'd1) >= len_ff);
   assign fin       = finish_cp(cat_cp, len_ff);

   // Next state and units caused by this byte
   always_comb begin
      n         = 2'd0;
      unit_v[0] = '0;
      unit_v[1] = '0;
      repl_v[0] = 1'b0;
      repl_v[1] = 1'b0;
      cp_in     = cp_ff;
      len_in    = len_ff;
      seen_in   = seen_ff;
      if (len_ff == 3'd0) begin
         if (lead.emit) begin
            unit_v[n[0]] = lead.unit;
            repl_v[n[0]] = (lead.unit == u8u16_pkg::REPLACEMENT_CHAR) && req_tdata[7];
            n = n + 2'd1;
         end else begin
            cp_in   = lead.cp;
            len_in  = lead.len;
            seen_in = 2'd0;
         end
      end else if (cont_byte) begin
         if (complete) begin
            cp_in     = '0;
            len_in    = '0;
            seen_in   = '0;
            unit_v[0] = fin.unit0;
            repl_v[0] = fin.repl0;
            unit_v[1] = fin.unit1;
            n         = fin.two ? 2'd2 : 2'd1;
         end else begin
            cp_in   = cat_cp;
            seen_in = seen_inc;
         end
      end else begin
         // Broken sequence: replace, then decode the byte again as a lead
         cp_in     = '0;
         len_in    = '0;
         seen_in   = '0;
         unit_v[0] = u8u16_pkg::REPLACEMENT_CHAR;
         repl_v[0] = 1'b1;
         n         = 2'd1;
         if (lead.emit) begin
            unit_v[n[0]] = lead.unit;
            repl_v[n[0]] = (lead.unit == u8u16_pkg::REPLACEMENT_CHAR) && req_tdata[7];
            n = n + 2'd1;
         end else begin
            cp_in   = lead.cp;
            len_in  = lead.len;
            seen_in = 2'd0;
         end
      end
      // Close a sequence left open at end of text
      if (req_tlast && (len_in != 3'd0)) begin
         cp_in   = '0;
         len_in  = '0;
         seen_in = '0;
         unit_v[n[0]] = u8u16_pkg::REPLACEMENT_CHAR;
         repl_v[n[0]] = 1'b1;
         n = n + 2'd1;
      end
   end

   // Hand the units to the queue
   assign push             = in_fire && (n != 2'd0);
   assign push_entry.two   = n[1];
   assign push_entry.unit0 = unit_v[0];
   assign push_entry.repl0 = repl_v[0];
   assign push_entry.unit1 = unit_v[1];
   assign push_entry.repl1 = repl_v[1];

   // Advance sequence state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff   <= '0;
         len_ff  <= '0;
         seen_ff <= '0;
      end else if (in_fire) begin
         cp_ff   <= cp_in;
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      (len_ff == 3'd0) |-> ((seen_ff == 2'd0) && (cp_ff == 21'd0)))
      else $error("closed sequence holds stale state");
   a_open_short: assert property (@(posedge clock) disable iff (reset)
      (len_ff != 3'd0) |-> ((({1'b0, seen_ff} + 3'd1) < len_ff) && (len_ff >= 3'd2)))
      else $error("open sequence already complete");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("push into full queue");

endmodule

// ===== rtl/u8u16_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder entry queue
// Short FIFO between the decoder and the unit serializer.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  u8u16_pkg::entry_type         push_entry,
   input  logic                         pop,
   output u8u16_pkg::entry_type         head,
   output u8u16_pkg::queue_status_type  status
);

   u8u16_pkg::entry_type               mem_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [u8u16_pkg::QUEUE_AW-1:0]     wr_ptr_ff;
   logic [u8u16_pkg::QUEUE_AW-1:0]     rd_ptr_ff;
   logic [u8u16_pkg::QUEUE_CW-1:0]     count_ff;
   logic [u8u16_pkg::QUEUE_CW-1:0]     count_in;

   assign status.full  = (count_ff == u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH))
      |-> (u8u16_pkg::QUEUE_AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[u8u16_pkg::QUEUE_AW-1:0]))
      else $error("queue pointers disagree with count");

endmodule

// ===== rtl/u8u16_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 unit serializer
// Sends the head entry's units (one or two), one per cycle unless stalled.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                         clock,
   input  logic                         reset,
   input  u8u16_pkg::entry_type         head,
   input  u8u16_pkg::queue_status_type  queue_status,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   logic sel_ff;
   logic sel_in;
   logic out_fire;

   // Pick the current unit of the head entry
   assign rsp_tvalid = !queue_status.empty;
   assign rsp_tdata  = sel_ff ? head.unit1 : head.unit0;
   assign rsp_tuser  = sel_ff ? head.repl1 : head.repl0;
   assign rsp_tlast  = sel_ff || !head.two;
   assign out_fire   = rsp_tvalid && rsp_tready;
   assign pop        = out_fire && rsp_tlast;

   // Step to the second unit or back to the first on pop
   always_comb begin
      sel_in = sel_ff;
      if (out_fire) begin
         sel_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   a_sel_on_pair: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (!queue_status.empty && head.two))
      else $error("second unit selected without a pair");
   a_pair_steps: assert property (@(posedge clock) disable iff (reset)
      (out_fire && !sel_ff && head.two) |=> sel_ff)
      else $error("pair did not advance to second unit");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> !sel_ff)
      else $error("select not cleared after pop");

endmodule

// ===== rtl/utf8_to_utf16_transcoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Byte stream in, UTF-16 code unit stream out, invalid input as U+FFFD.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle while its queue has room and sends
// one UTF-16 code unit per cycle while rsp_tready is high. A byte's units
// are in the four-entry queue in the cycle after it is accepted. A byte that
// causes two units (a surrogate pair, or a replacement followed by a second
// unit) holds the result side for both units, so the input rate drops below
// one byte per cycle when such bytes arrive faster than the result side
// drains them, or when the receiver stalls. rsp_tlast marks the final unit
// caused by one byte; rsp_tuser flags a U+FFFD that stands for invalid input.
module utf8_to_utf16_transcoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tuser,   // [0] replaced
   output logic        rsp_tlast    // last_of_run
);

   u8u16_pkg::queue_status_type queue_status;
   u8u16_pkg::entry_type        push_entry;
   u8u16_pkg::entry_type        head;
   logic                        push;
   logic                        pop;

   // Decode bytes
   u8u16_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Buffer entries
   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // Send units
   u8u16_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Streams UTF-8 bytes into the transcoder and checks every UTF-16 code unit
// against a cycle-free decoder kept in the bench. A short directed list covers
// the invalid forms, then a random mix of mostly well-formed characters with
// truncated sequences and stray bytes follows. Both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BYTES = 750;
   localparam int PHASE_SWAP   = 260;   // bytes taken before idling swaps sides
   localparam int PHASE_FREE   = 520;   // bytes taken before idling stops
   localparam int PRESSURE_AT  = 600;   // bytes taken when the long hold starts
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        replaced;
      logic        last_of_run;
   } code_unit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] text_byte
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] code_unit
   logic        rsp_tuser;           // [0] replaced
   logic        rsp_tlast;           // last_of_run

   text_item_type  text_bytes_pending[$];
   code_unit_type  expected_units[$];
   code_unit_type  byte_units[$];
   text_item_type  next_item;
   int             bytes_taken = 0;
   int             fail_count = 0;
   int             hold_left = 0;
   logic           hold_used = 1'b0;

   // decoder state: code point bits so far, open length, continuations seen
   logic [20:0] cp_acc = '0;
   logic [2:0]  open_len = '0;
   logic [1:0]  cont_count = '0;

   utf8_to_utf16_transcoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic void add_unit(input logic [15:0] unit, input logic repl);
      byte_units.push_back('{unit, repl, 1'b0});
   endfunction

   function automatic void close_char();
      cp_acc     = '0;
      open_len   = '0;
      cont_count = '0;
   endfunction

   // Treat a byte as the start of a character
   function automatic void start_char(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         add_unit({8'h00, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
         cp_acc = {16'h0, b[4:0]};
         open_len = 3'd2;
         cont_count = '0;
      end else if (b[7:4] == 4'b1110) begin
         cp_acc = {17'h0, b[3:0]};
         open_len = 3'd3;
         cont_count = '0;
      end else if (b[7:3] == 5'b11110) begin
         cp_acc = {18'h0, b[2:0]};
         open_len = 3'd4;
         cont_count = '0;
      end else begin
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
      end
   endfunction

   // Validate a finished code point and turn it into one or two units
   function automatic void encode_code_point(input logic [20:0] cp, input logic [2:0] len);
      logic [2:0]  shortest;
      logic [20:0] offset;
      shortest = (cp <= 21'h7F) ? 3'd1 : (cp <= 21'h7FF) ? 3'd2 :
                 (cp <= 21'hFFFF) ? 3'd3 : 3'd4;
      if (shortest != len) begin
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
      end else if (cp < 21'hFFFF &&
                   (cp[15:0] & u8u16_pkg::SURR_MASK) == u8u16_pkg::HIGH_SURR_BASE) begin
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
      end else if (cp > u8u16_pkg::MAX_CODE_POINT) begin
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
      end else if (cp <= 21'hFFFF) begin
         add_unit(cp[15:0], 1'b0);
      end else begin
         offset = cp - u8u16_pkg::SUPP_OFFSET;
         add_unit(u8u16_pkg::HIGH_SURR_BASE | {6'h00, offset[19:10]}, 1'b0);
         add_unit(u8u16_pkg::LOW_SURR_BASE | {6'h00, offset[9:0]}, 1'b0);
      end
   endfunction

   // Advance the decoder by one accepted byte and queue the units it causes
   function automatic void decode_byte(input logic [7:0] b, input logic eot);
      logic [20:0] cp;
      logic [2:0]  len;
      byte_units.delete();
      if (open_len == 3'd0) begin
         start_char(b);
      end else if (b[7:6] == 2'b10) begin
         cp_acc = {cp_acc[14:0], b[5:0]};
         cont_count = cont_count + 2'd1;
         if (int'(cont_count) + 1 >= int'(open_len)) begin
            cp = cp_acc;
            len = open_len;
            close_char();
            encode_code_point(cp, len);
         end
      end else begin
         // broken sequence: replace, then decode the byte again as a lead
         close_char();
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
         start_char(b);
      end
      if (eot && open_len != 3'd0) begin
         close_char();
         add_unit(u8u16_pkg::REPLACEMENT_CHAR, 1'b1);
      end
      if (byte_units.size() != 0)
         byte_units[byte_units.size() - 1].last_of_run = 1'b1;
      foreach (byte_units[i])
         expected_units.push_back(byte_units[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Idling per phase of the run
   // ------------------------------------------------------------------------
   function automatic int send_idle_pct();
      if (bytes_taken < PHASE_SWAP) return 6;
      if (bytes_taken < PHASE_FREE) return 80;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (bytes_taken < PHASE_SWAP) return 80;
      if (bytes_taken < PHASE_FREE) return 6;
      return 0;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offer pending bytes, predict on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (text_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
               next_item = text_bytes_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.text_byte;
               req_tlast  <= next_item.end_of_text;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver ready: random stalls plus one long hold to back up the block
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_used  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_used && bytes_taken >= PRESSURE_AT) begin
         hold_used  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each accepted unit with the oldest expectation
   // ------------------------------------------------------------------------
   function automatic void flag_unit(input string what, input code_unit_type want,
                                     input code_unit_type got);
      if (fail_count < REPORT_MAX)
         $display("%0t: %s: expected unit %h repl %b last %b, got unit %h repl %b last %b",
                  $realtime, what, want.code_unit, want.replaced, want.last_of_run,
                  got.code_unit, got.replaced, got.last_of_run);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      code_unit_type got;
      code_unit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser, rsp_tlast};
         if (expected_units.size() == 0) begin
            flag_unit("unit with nothing expected", '0, got);
         end else begin
            want = expected_units.pop_front();
            if (got.code_unit != want.code_unit || got.replaced != want.replaced ||
                got.last_of_run != want.last_of_run)
               flag_unit("unit mismatch", want, got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_raw(input logic [7:0] b, input logic eot);
      text_bytes_pending.push_back('{b, eot});
   endtask

   // Encode cp in nbytes bytes whether or not that is legal; push the first keep
   task automatic push_char(input logic [20:0] cp, input int nbytes, input int keep,
                            input logic eot);
      logic [7:0] seq [4];
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      case (nbytes)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: seq[0] = {5'b11110, cp[20:18]};
      endcase
      for (int i = 0; i < keep; i++)
         push_raw(seq[i], eot && (i == keep - 1));
   endtask

   initial begin
      int start_count;
      int pick;
      int len;
      logic eot;

      // directed: extremes and each invalid form
      push_raw(8'h00, 1'b0);                     // NUL is an ordinary character
      push_raw(8'h80, 1'b0);                     // stray continuation byte
      push_raw(8'hFF, 1'b0);                     // 11111xxx lead
      push_raw(8'h41, 1'b1);                     // end of text with nothing open
      push_char(21'h000080, 2, 2, 1'b0);         // smallest two-byte character
      push_char(21'h000000, 2, 2, 1'b0);         // overlong NUL
      push_char(21'h00D800, 3, 3, 1'b0);         // encoded surrogate
      push_char(21'h110000, 4, 4, 1'b0);         // above the last code point
      push_char(21'h01F600, 4, 4, 1'b0);         // surrogate pair
      push_raw(8'hE2, 1'b0);                     // lead cut by an ASCII byte
      push_raw(8'h41, 1'b0);
      push_raw(8'hE2, 1'b0);                     // lead cut by a lead left open at end
      push_raw(8'hC3, 1'b1);
      push_char(21'h00FFFD, 3, 3, 1'b0);         // genuine U+FFFD
      push_raw(8'hF0, 1'b1);                     // four-byte lead alone at end

      // random: mostly well-formed characters, some broken forms and noise
      start_count = text_bytes_pending.size();
      while (text_bytes_pending.size() < start_count + RANDOM_BYTES) begin
         pick = $urandom_range(99);
         eot = ($urandom_range(24) == 0);
         if (pick < 20) begin
            push_char(21'($urandom_range(21'h7F, 0)), 1, 1, eot);
         end else if (pick < 35) begin
            push_char(21'($urandom_range(21'h7FF, 21'h80)), 2, 2, eot);
         end else if (pick < 55) begin
            push_char(21'($urandom_range(21'hFFFF, 21'h800)), 3, 3, eot);
         end else if (pick < 75) begin
            push_char(21'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4, eot);
         end else if (pick < 80) begin
            // overlong form
            len = $urandom_range(4, 2);
            push_char(21'($urandom_range((len == 2) ? 21'h7F : (len == 3) ? 21'h7FF :
                                         21'hFFFF, 0)),
                      len, len, eot);
         end else if (pick < 84) begin
            push_char(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4, eot);
         end else if (pick < 88) begin
            push_char(21'($urandom_range(21'hDFFF, 21'hD800)), 3, 3, eot);
         end else if (pick < 94) begin
            // truncated sequence, often left open at end of text
            len = $urandom_range(4, 2);
            push_char(21'($urandom_range(21'h1FFFFF, 0)), len,
                      int'($urandom_range(len - 1, 1)), 1'($urandom_range(1)));
         end else begin
            push_raw(8'($urandom_range(255)), eot);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: all bytes taken and every expected unit seen
      while (text_bytes_pending.size() != 0 || req_tvalid || expected_units.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_units.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
